// ===== sv/ffpra_pkg.sv =====
// Shared types and defaults for the first-fit page region allocator.
// Used by first_fit_page_region_allocator_top; depends on nothing.
package ffpra_pkg;

  localparam int unsigned MaxRegionsDef = 64;
  localparam int unsigned PageShiftDef  = 12;

  localparam logic [1:0] CmdAlloc  = 2'd0;
  localparam logic [1:0] CmdFree   = 2'd1;
  localparam logic [1:0] CmdAppend = 2'd2;

  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StNoFit  = 2'd1;
  localparam logic [1:0] StFull   = 2'd2;

  localparam logic [3:0] KindFree   = 4'd0;
  localparam logic [3:0] KindLoader = 4'd1;

  // One region table entry.
  typedef struct packed {
    logic [63:0] base;
    logic [63:0] size;
    logic [3:0]  kind;
  } entry_t;

endpackage

// ===== sv/first_fit_page_region_allocator_top.sv =====
// First-fit page region allocator: region table memory and its sequencer.
// Depends on ffpra_pkg.
//
// Usage: one command item enters on the s_axis group (tdata, low bit up:
// cmd[1:0], size_bytes[65:2], region_type[69:66], base_addr[133:70], zero
// fill to 136). One result item leaves on the m_axis group for every command.
// The table sits in a single-port-write, single-port-read memory with a
// registered read, and one sequencer walks it. Each table entry visited in a
// search takes a read state and a check state; each entry moved takes a read
// state and a write state. An allocate takes the first free entry that is
// large enough: it retypes it on an exact fit, else splits it and moves the
// later entries up; a search that finds nothing returns no-fit. A free that
// matches a loader entry may merge forward and backward, each merge closing
// the gap entry by entry. s_axis_tready is high only while the sequencer is
// idle; a finished result waits in the output register, and the next command
// is taken meanwhile, but its result stalls until the receiver has taken the
// one before. Reset empties the table and clears both byte counters at once;
// no clearing pass is needed.
module first_fit_page_region_allocator_top #(
  parameter int unsigned MAX_REGIONS = ffpra_pkg::MaxRegionsDef,
  parameter int unsigned PAGE_SHIFT  = ffpra_pkg::PageShiftDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // cmd[1:0], size_bytes[65:2], region_type[69:66], base_addr[133:70], zero fill
  input  logic [135:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[1:0], alloc_addr[65:2], loader_bytes[129:66], kernel_bytes[193:130],
  // region_count[200:194], zero fill
  output logic [207:0] m_axis_tdata
);

  localparam int unsigned IW = $clog2(MAX_REGIONS);
  localparam int unsigned CW = $clog2(MAX_REGIONS + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_REGIONS);
  localparam logic [CW-1:0] One    = CW'(1);
  localparam logic [63:0] PageMask = (64'd1 << PAGE_SHIFT) - 64'd1;

  typedef enum logic [4:0] {
    S_IDLE, S_CMD, S_A_RD, S_A_CHK, S_A_SHRD, S_A_SHWR, S_A_WR1, S_A_WR0,
    S_F_RD, S_F_CHK, S_F_NRD, S_F_NCHK, S_F_WCUR, S_F_DRD, S_F_DWR,
    S_F_PRD, S_F_PCHK, S_DONE
  } state_e;

  state_e state_q;

  // Table memory
  ffpra_pkg::entry_t mem_q [MAX_REGIONS];
  ffpra_pkg::entry_t rd_q;
  logic              we;
  logic [IW-1:0]     waddr, raddr;
  ffpra_pkg::entry_t wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rd_q <= mem_q[raddr];
  end

  // Command and working registers
  logic [1:0]  cmd_q;
  logic [63:0] sz_q, base_q;
  logic [3:0]  kind_q;
  logic        ovf_q;
  logic [CW-1:0] cnt_q, i_q, k_q;
  ffpra_pkg::entry_t cur_q;
  logic        fwd_q, back_q;
  logic [1:0]  st_q;
  logic [63:0] addr_q, ldr_q, krn_q;

  logic        out_valid_q;
  logic [1:0]  o_status_q;
  logic [63:0] o_addr_q, o_ldr_q, o_krn_q;
  logic [6:0]  o_cnt_q;
  logic        out_load;

  // Input field unpacking and page round-up
  logic [1:0]  in_cmd;
  logic [63:0] in_size, in_base, in_round;
  logic [3:0]  in_type;
  assign in_cmd   = s_axis_tdata[1:0];
  assign in_size  = s_axis_tdata[65:2];
  assign in_type  = s_axis_tdata[69:66];
  assign in_base  = s_axis_tdata[133:70];
  assign in_round = (in_size + PageMask) & ~PageMask;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, o_cnt_q, o_krn_q, o_ldr_q, o_addr_q, o_status_q};

  // Load the output register once it is free or being emptied
  assign out_load = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

  // Shared adders and compares
  logic [63:0] sum_cur, sum_rd;
  logic [64:0] sum_merge, cnt_add;
  logic [63:0] merge_sat;
  logic [CW-1:0] i_p1;
  assign sum_cur   = cur_q.base + cur_q.size;
  assign sum_rd    = rd_q.base + rd_q.size;
  assign sum_merge = {1'b0, rd_q.size} + {1'b0, cur_q.size};
  assign merge_sat = sum_merge[64] ? '1 : sum_merge[63:0];
  assign i_p1      = i_q + One;
  assign cnt_add   = (kind_q == ffpra_pkg::KindLoader) ? ({1'b0, ldr_q} + {1'b0, sz_q})
                                                       : ({1'b0, krn_q} + {1'b0, sz_q});

  // Memory port selection
  always_comb begin
    we    = 1'b0;
    waddr = i_q[IW-1:0];
    wdata = cur_q;
    raddr = i_q[IW-1:0];
    unique case (state_q)
      S_CMD: begin
        waddr = cnt_q[IW-1:0];
        wdata = '{base: base_q, size: sz_q, kind: kind_q};
        we    = (cmd_q == ffpra_pkg::CmdAppend) && (cnt_q < MaxCnt);
      end
      S_A_CHK: begin
        wdata = '{base: rd_q.base, size: rd_q.size, kind: kind_q};
        we    = (rd_q.kind == ffpra_pkg::KindFree) && (rd_q.size == sz_q);
      end
      S_A_SHRD: raddr = k_q[IW-1:0] - IW'(1);
      S_A_SHWR: begin
        we    = 1'b1;
        waddr = k_q[IW-1:0];
        wdata = rd_q;
      end
      S_A_WR1: begin
        we    = 1'b1;
        waddr = i_p1[IW-1:0];
        wdata = '{base: cur_q.base + sz_q, size: cur_q.size - sz_q,
                  kind: ffpra_pkg::KindFree};
      end
      S_A_WR0: begin
        we    = 1'b1;
        wdata = '{base: cur_q.base, size: sz_q, kind: kind_q};
      end
      S_F_NRD: raddr = i_p1[IW-1:0];
      S_F_WCUR: we = 1'b1;
      S_F_DRD: raddr = k_q[IW-1:0] + IW'(1);
      S_F_DWR: begin
        we    = 1'b1;
        waddr = k_q[IW-1:0];
        wdata = rd_q;
      end
      S_F_PRD: raddr = i_q[IW-1:0] - IW'(1);
      S_F_PCHK: begin
        waddr = i_q[IW-1:0] - IW'(1);
        wdata = '{base: rd_q.base, size: merge_sat, kind: rd_q.kind};
        we    = (rd_q.kind == ffpra_pkg::KindFree) && (sum_rd == cur_q.base);
      end
      default: ;
    endcase
  end

  // Sequencer, counters and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      ldr_q       <= '0;
      krn_q       <= '0;
      out_valid_q <= 1'b0;
      cmd_q       <= '0;
      sz_q        <= '0;
      base_q      <= '0;
      kind_q      <= '0;
      ovf_q       <= 1'b0;
      i_q         <= '0;
      k_q         <= '0;
      cur_q       <= '0;
      fwd_q       <= 1'b0;
      back_q      <= 1'b0;
      st_q        <= '0;
      addr_q      <= '0;
      o_status_q  <= '0;
      o_addr_q    <= '0;
      o_ldr_q     <= '0;
      o_krn_q     <= '0;
      o_cnt_q     <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            cmd_q  <= in_cmd;
            base_q <= in_base;
            ovf_q  <= (in_size > ~PageMask);
            sz_q   <= (in_cmd == ffpra_pkg::CmdAppend) ? in_size : in_round;
            kind_q <= (in_cmd == ffpra_pkg::CmdAlloc && in_type == ffpra_pkg::KindFree)
                      ? ffpra_pkg::KindLoader : in_type;
            i_q    <= '0;
            fwd_q  <= 1'b0;
            addr_q <= '0;
            state_q <= S_CMD;
          end
        end
        // Dispatch the command
        S_CMD: begin
          st_q    <= ffpra_pkg::StNoFit;
          state_q <= S_DONE;
          unique case (cmd_q)
            ffpra_pkg::CmdAlloc:  if (!ovf_q) state_q <= S_A_RD;
            ffpra_pkg::CmdFree:   if (!ovf_q) state_q <= S_F_RD;
            ffpra_pkg::CmdAppend: begin
              if (cnt_q < MaxCnt) begin
                st_q  <= ffpra_pkg::StOk;
                cnt_q <= cnt_q + One;
              end else begin
                st_q  <= ffpra_pkg::StFull;
              end
            end
            default: ;
          endcase
        end
        // Allocate: first-fit search
        S_A_RD: begin
          if (i_q >= cnt_q) begin
            st_q    <= ffpra_pkg::StNoFit;
            state_q <= S_DONE;
          end else begin
            state_q <= S_A_CHK;
          end
        end
        S_A_CHK: begin
          if (rd_q.kind != ffpra_pkg::KindFree || rd_q.size < sz_q) begin
            i_q     <= i_p1;
            state_q <= S_A_RD;
          end else if (rd_q.size == sz_q) begin
            if (kind_q == ffpra_pkg::KindLoader) ldr_q <= cnt_add[64] ? '1 : cnt_add[63:0];
            else krn_q <= cnt_add[64] ? '1 : cnt_add[63:0];
            addr_q  <= rd_q.base;
            st_q    <= ffpra_pkg::StOk;
            state_q <= S_DONE;
          end else if (cnt_q >= MaxCnt) begin
            st_q    <= ffpra_pkg::StFull;
            state_q <= S_DONE;
          end else begin
            cur_q   <= rd_q;
            k_q     <= cnt_q;
            state_q <= (cnt_q > i_p1) ? S_A_SHRD : S_A_WR1;
          end
        end
        // Allocate: move later entries up one slot
        S_A_SHRD: state_q <= S_A_SHWR;
        S_A_SHWR: begin
          k_q     <= k_q - One;
          state_q <= ((k_q - One) > i_p1) ? S_A_SHRD : S_A_WR1;
        end
        S_A_WR1: state_q <= S_A_WR0;
        S_A_WR0: begin
          if (kind_q == ffpra_pkg::KindLoader) ldr_q <= cnt_add[64] ? '1 : cnt_add[63:0];
          else krn_q <= cnt_add[64] ? '1 : cnt_add[63:0];
          cnt_q   <= cnt_q + One;
          addr_q  <= cur_q.base;
          st_q    <= ffpra_pkg::StOk;
          state_q <= S_DONE;
        end
        // Free: exact loader match search
        S_F_RD: begin
          if (i_q >= cnt_q) begin
            st_q    <= ffpra_pkg::StNoFit;
            state_q <= S_DONE;
          end else begin
            state_q <= S_F_CHK;
          end
        end
        S_F_CHK: begin
          if (rd_q.kind == ffpra_pkg::KindLoader && rd_q.base == base_q &&
              rd_q.size == sz_q) begin
            cur_q   <= '{base: rd_q.base, size: rd_q.size, kind: ffpra_pkg::KindFree};
            ldr_q   <= (ldr_q >= sz_q) ? ldr_q - sz_q : '0;
            st_q    <= ffpra_pkg::StOk;
            state_q <= (i_p1 < cnt_q) ? S_F_NRD : S_F_WCUR;
          end else begin
            i_q     <= i_p1;
            state_q <= S_F_RD;
          end
        end
        // Free: forward merge check
        S_F_NRD: state_q <= S_F_NCHK;
        S_F_NCHK: begin
          if (rd_q.kind == ffpra_pkg::KindFree && rd_q.base == sum_cur) begin
            cur_q.size <= merge_sat;
            fwd_q      <= 1'b1;
          end
          state_q <= S_F_WCUR;
        end
        S_F_WCUR: begin
          if (fwd_q) begin
            k_q     <= i_p1;
            back_q  <= 1'b0;
            state_q <= S_F_DRD;
          end else begin
            state_q <= (i_q != '0) ? S_F_PRD : S_DONE;
          end
        end
        // Free: close the gap, one entry at a time
        S_F_DRD: begin
          if ((k_q + One) < cnt_q) begin
            state_q <= S_F_DWR;
          end else begin
            cnt_q <= cnt_q - One;
            if (back_q) state_q <= S_DONE;
            else        state_q <= (i_q != '0) ? S_F_PRD : S_DONE;
          end
        end
        S_F_DWR: begin
          k_q     <= k_q + One;
          state_q <= S_F_DRD;
        end
        // Free: backward merge check
        S_F_PRD: state_q <= S_F_PCHK;
        S_F_PCHK: begin
          if (rd_q.kind == ffpra_pkg::KindFree && sum_rd == cur_q.base) begin
            k_q     <= i_q;
            back_q  <= 1'b1;
            state_q <= S_F_DRD;
          end else begin
            state_q <= S_DONE;
          end
        end
        // Hand the result over once the output register is free
        S_DONE: begin
          if (out_load) begin
            o_status_q  <= st_q;
            o_addr_q    <= addr_q;
            o_ldr_q     <= ldr_q;
            o_krn_q     <= krn_q;
            o_cnt_q     <= 7'(cnt_q);
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sim/first_fit_page_region_allocator_top_tb.sv =====
// Testbench for first_fit_page_region_allocator_top: drives command items,
// predicts each result with a local copy of the region table and checks it.
// Depends on ffpra_pkg and the top level.
module first_fit_page_region_allocator_top_tb;

  localparam int unsigned NumRegions = ffpra_pkg::MaxRegionsDef;
  localparam int unsigned PgShift    = ffpra_pkg::PageShiftDef;
  localparam logic [63:0] PgMask     = (64'd1 << PgShift) - 64'd1;
  localparam logic [63:0] AllOnes    = {64{1'b1}};
  localparam logic [1:0]  CmdUnused  = 2'd3;
  localparam int unsigned CycleLimit = 2000000;

  // Fields from the highest bit down, so status lands in the lowest bits
  typedef struct packed {
    logic [6:0]  region_count;
    logic [63:0] kernel_bytes;
    logic [63:0] loader_bytes;
    logic [63:0] alloc_addr;
    logic [1:0]  status;
  } result_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [207:0] m_axis_tdata;

  // Predictor state
  logic [63:0] tbl_base [NumRegions];
  logic [63:0] tbl_size [NumRegions];
  logic [3:0]  tbl_kind [NumRegions];
  int unsigned tbl_count;
  logic [63:0] loader_sum;
  logic [63:0] kernel_sum;

  result_t     pending_results[$];
  int unsigned mismatches;
  int unsigned cycles;

  first_fit_page_region_allocator_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? AllOnes : s[63:0];
  endfunction

  function automatic void shift_down_from(int unsigned idx);
    for (int unsigned k = idx; k + 1 < tbl_count; k++) begin
      tbl_base[k] = tbl_base[k+1];
      tbl_size[k] = tbl_size[k+1];
      tbl_kind[k] = tbl_kind[k+1];
    end
    tbl_count--;
  endfunction

  // Work out the result of one command and update the predicted table
  function automatic result_t predict_command(logic [1:0] cmd, logic [63:0] sz,
                                              logic [3:0] kind, logic [63:0] base);
    result_t     r;
    logic [63:0] psz;
    bit          done;
    r = '0;
    r.status = ffpra_pkg::StNoFit;
    done = 0;
    psz = (sz + PgMask) & ~PgMask;
    if (cmd == ffpra_pkg::CmdAlloc && sz <= AllOnes - PgMask) begin
      if (kind < ffpra_pkg::KindLoader) kind = ffpra_pkg::KindLoader;
      for (int unsigned i = 0; i < tbl_count && !done; i++) begin
        if (tbl_kind[i] != ffpra_pkg::KindFree || tbl_size[i] < psz) continue;
        done = 1;
        if (tbl_size[i] != psz) begin
          if (tbl_count >= NumRegions) begin
            r.status = ffpra_pkg::StFull;
            break;
          end
          for (int unsigned k = tbl_count; k > i + 1; k--) begin
            tbl_base[k] = tbl_base[k-1];
            tbl_size[k] = tbl_size[k-1];
            tbl_kind[k] = tbl_kind[k-1];
          end
          tbl_kind[i+1] = ffpra_pkg::KindFree;
          tbl_base[i+1] = tbl_base[i] + psz;
          tbl_size[i+1] = tbl_size[i] - psz;
          tbl_size[i]   = psz;
          tbl_count++;
        end
        tbl_kind[i] = kind;
        if (kind == ffpra_pkg::KindLoader) loader_sum = sat_sum(loader_sum, psz);
        else kernel_sum = sat_sum(kernel_sum, psz);
        r.alloc_addr = tbl_base[i];
        r.status = ffpra_pkg::StOk;
      end
    end else if (cmd == ffpra_pkg::CmdFree && sz <= AllOnes - PgMask) begin
      for (int unsigned i = 0; i < tbl_count && !done; i++) begin
        if (tbl_kind[i] != ffpra_pkg::KindLoader || tbl_base[i] != base ||
            tbl_size[i] != psz)
          continue;
        done = 1;
        r.status = ffpra_pkg::StOk;
        tbl_kind[i] = ffpra_pkg::KindFree;
        loader_sum = (loader_sum >= psz) ? loader_sum - psz : 64'd0;
        if (i + 1 < tbl_count && tbl_kind[i+1] == ffpra_pkg::KindFree &&
            tbl_base[i+1] == tbl_base[i] + tbl_size[i]) begin
          tbl_size[i] = sat_sum(tbl_size[i], tbl_size[i+1]);
          shift_down_from(i + 1);
        end
        if (i > 0 && tbl_kind[i-1] == ffpra_pkg::KindFree &&
            tbl_base[i-1] + tbl_size[i-1] == tbl_base[i]) begin
          tbl_size[i-1] = sat_sum(tbl_size[i-1], tbl_size[i]);
          shift_down_from(i);
        end
      end
    end else if (cmd == ffpra_pkg::CmdAppend) begin
      if (tbl_count >= NumRegions) r.status = ffpra_pkg::StFull;
      else begin
        tbl_base[tbl_count] = base;
        tbl_size[tbl_count] = sz;
        tbl_kind[tbl_count] = kind;
        tbl_count++;
        r.status = ffpra_pkg::StOk;
      end
    end
    r.loader_bytes = loader_sum;
    r.kernel_bytes = kernel_sum;
    r.region_count = tbl_count[6:0];
    return r;
  endfunction

  // Random gap: mostly short, a few long
  function automatic int unsigned idle_gap();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 40) return 0;
    if (p < 92) return $urandom_range(3);
    return $urandom_range(60, 10);
  endfunction

  // Send one command item and log its expected result; valid stays high
  // across back-to-back items and drops only for a gap
  task automatic send_command(logic [1:0] cmd, logic [63:0] sz,
                              logic [3:0] kind, logic [63:0] base);
    int unsigned gap;
    gap = idle_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= {2'b00, base, kind, sz, cmd};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(predict_command(cmd, sz, kind, base));
  endtask

  // Drop valid, wait for every result, then let the sequencer settle
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  // Receiver stalls
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready <= (idle_gap() == 0) || ($urandom_range(1) == 1);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[200:0];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.alloc_addr !== want.alloc_addr ||
            got.loader_bytes !== want.loader_bytes ||
            got.kernel_bytes !== want.kernel_bytes ||
            got.region_count !== want.region_count) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected st=%0d addr=%h ld=%h kn=%h n=%0d",
                     want.status, want.alloc_addr, want.loader_bytes,
                     want.kernel_bytes, want.region_count);
            $display("          got      st=%0d addr=%h ld=%h kn=%h n=%0d",
                     got.status, got.alloc_addr, got.loader_bytes,
                     got.kernel_bytes, got.region_count);
          end
        end
      end
    end
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Pick a size in bytes, mostly a small number of whole pages
  function automatic logic [63:0] rand_size();
    case ($urandom_range(9))
      0: return rand64();
      1: return 64'($urandom_range(8191));
      default: return 64'($urandom_range(16, 1)) << PgShift;
    endcase
  endfunction

  // Extremes, every command and each corner case
  task automatic test_directed();
    send_command(ffpra_pkg::CmdAlloc, 64'h1000, ffpra_pkg::KindLoader, 64'd0);
    send_command(ffpra_pkg::CmdFree, 64'h1000, ffpra_pkg::KindFree, 64'd0);
    send_command(CmdUnused, AllOnes, 4'hF, AllOnes);
    send_command(ffpra_pkg::CmdAppend, 64'h10_0000, ffpra_pkg::KindFree, 64'h10_0000);
    send_command(ffpra_pkg::CmdAppend, 64'h0, ffpra_pkg::KindFree, 64'h50_0000);
    send_command(ffpra_pkg::CmdAppend, AllOnes, ffpra_pkg::KindFree,
                 64'hFFFF_0000_0000_0000);
    send_command(ffpra_pkg::CmdAppend, 64'h2000, ffpra_pkg::KindLoader, 64'h90_0000);
    send_command(ffpra_pkg::CmdAlloc, AllOnes, ffpra_pkg::KindLoader, 64'd0);
    send_command(ffpra_pkg::CmdAlloc, 64'd0, ffpra_pkg::KindFree, 64'd0);
    send_command(ffpra_pkg::CmdAlloc, 64'd1, 4'hF, 64'd0);
    send_command(ffpra_pkg::CmdAlloc, 64'h1000, 4'h5, 64'd0);
    send_command(ffpra_pkg::CmdAlloc, 64'hFFF, ffpra_pkg::KindFree, 64'd0);
    send_command(ffpra_pkg::CmdFree, 64'h1, ffpra_pkg::KindFree, 64'h10_2000);
    send_command(ffpra_pkg::CmdFree, AllOnes, ffpra_pkg::KindFree, 64'h10_0000);
    send_command(ffpra_pkg::CmdFree, 64'h2000, ffpra_pkg::KindFree, 64'h90_0000);
    send_command(ffpra_pkg::CmdAlloc, AllOnes - PgMask, ffpra_pkg::KindLoader, 64'd0);
    send_command(ffpra_pkg::CmdAlloc, 64'h8000_0000_0000_0000, ffpra_pkg::KindLoader,
                 64'd0);
    send_command(ffpra_pkg::CmdFree, 64'h8000_0000_0000_0000, ffpra_pkg::KindFree,
                 64'hFFFF_0000_0000_0000);
    // Fill the table, then provoke both full cases
    for (int i = 0; i < 61; i++)
      send_command(ffpra_pkg::CmdAppend, 64'h1000, ffpra_pkg::KindFree,
                   64'h4000_0000 + 64'(i) * 64'h2000);
    send_command(ffpra_pkg::CmdAppend, 64'h1000, ffpra_pkg::KindFree, 64'h0);
    send_command(ffpra_pkg::CmdAlloc, 64'h800, ffpra_pkg::KindLoader, 64'd0);
    drain_results();
  endtask

  // Well-formed traffic over a firmware map, plus noise
  task automatic test_random(int unsigned n);
    logic [63:0] held_base [$];
    logic [63:0] held_size [$];
    result_t     r;
    int unsigned p, j;
    for (int unsigned i = 0; i < n; i++) begin
      p = $urandom_range(99);
      if (p < 45) begin
        send_command(ffpra_pkg::CmdAlloc, rand_size(), 4'($urandom_range(3)), rand64());
        r = pending_results[$];
        if (r.status == ffpra_pkg::StOk && tbl_count > 0) begin
          for (int unsigned k = 0; k < tbl_count; k++)
            if (tbl_base[k] == r.alloc_addr && tbl_kind[k] == ffpra_pkg::KindLoader) begin
              held_base.push_back(tbl_base[k]);
              held_size.push_back(tbl_size[k] - $urandom_range(1) *
                                  64'($urandom_range(32'(PgMask))));
            end
        end
      end else if (p < 80 && held_base.size() != 0) begin
        j = $urandom_range(held_base.size() - 1);
        send_command(ffpra_pkg::CmdFree, held_size[j], 4'($urandom()), held_base[j]);
        held_base.delete(j);
        held_size.delete(j);
      end else if (p < 88 && tbl_count < 40) begin
        send_command(ffpra_pkg::CmdAppend, 64'($urandom_range(64, 1)) << PgShift,
                     4'($urandom_range(99) < 70 ? 0 : $urandom()),
                     64'($urandom_range(255)) << 20);
      end else begin
        send_command(2'($urandom()), rand64(), 4'($urandom()), rand64());
      end
    end
    drain_results();
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    mismatches    = 0;
    cycles        = 0;
    tbl_count     = 0;
    loader_sum    = '0;
    kernel_sum    = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(1000);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
